@@ hw/rtl/ars_pkg.sv @@
// ----------------------------------------------------------------------------
// ars_pkg
// Shared widths, reset values, register indexes and state codes for the
// rectangle-scheme advection stencil.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int VALUE_W     = 64;
  localparam int COEF_W      = 63;
  localparam int WIDTH_W     = 11;
  localparam int ROW_W       = 16;
  localparam int COL_OUT_W   = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int FRAC_W  = 56;
  localparam int LIMB_W  = 32;
  localparam int PROD_W  = 2 * LIMB_W;
  localparam int MAG_W   = 66;
  localparam int SUM_W   = 66;
  localparam int NUM_W   = 68;
  localparam int ACC_W   = 128;
  localparam int QH_W    = ACC_W - FRAC_W - VALUE_W;
  localparam int STEP_W  = 3;

  localparam logic [STEP_W-1:0] MUL_LAST = 3'd6;

  localparam logic [VALUE_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [ACC_W-1:0] ROUND_ADD =
    {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

  localparam logic [COEF_W-1:0]  COURANT_RESET      = 63'd72057594037927936;
  localparam logic [COEF_W-1:0]  INV_DENOM_RESET    = 63'd36028797018963968;
  localparam logic [COEF_W-1:0]  SOURCE_SCALE_RESET = 63'd36028797;
  localparam logic [WIDTH_W-1:0] GRID_WIDTH_RESET   = 11'd1001;
  localparam logic [ROW_W-1:0]   GRID_HEIGHT_RESET  = 16'd1001;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COURANT      = 3'd0,
    CFG_INV_DENOM    = 3'd1,
    CFG_SOURCE_SCALE = 3'd2,
    CFG_GRID_WIDTH   = 3'd3,
    CFG_GRID_HEIGHT  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD_C,
    ST_MUL_C,
    ST_RND_C,
    ST_MUL_S,
    ST_NUM,
    ST_LOAD_R,
    ST_MUL_R,
    ST_RND_R,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/ars_if.sv @@
// ----------------------------------------------------------------------------
// ars_if
// Valid/ready channels of the advection stencil: configuration writes,
// boundary words in and grid point words out.
// ----------------------------------------------------------------------------
interface ars_cfg_if
  import ars_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface ars_in_if
  import ars_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] boundary_value;

  modport source (output valid, output boundary_value, input ready);
  modport sink (input valid, input boundary_value, output ready);
endinterface

interface ars_out_if
  import ars_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] point_value;
  logic [ROW_W-1:0]          time_row;
  logic [COL_OUT_W-1:0]      space_column;
  logic                      grid_done;

  modport source (output valid, output point_value, output time_row,
                  output space_column, output grid_done, input ready);
  modport sink (input valid, input point_value, input time_row,
                input space_column, input grid_done, output ready);
endinterface

@@ hw/rtl/advection_rectangle_stencil.sv @@
// ----------------------------------------------------------------------------
// advection_rectangle_stencil
// Rectangle-scheme solver for u_t + a*u_x = x*t over a streamed grid.
// ----------------------------------------------------------------------------
// Grid points are taken one word at a time, row by row in time and column by
// column in space; each boundary word yields one point word. Points on row
// zero or column zero pass the boundary value through, going from the read
// state straight to completion. Every other point needs three 66 by 63 bit
// products (Courant term, source term, reciprocal scaling), each built from
// six 32 by 32 partial products on one shared multiplier feeding a
// registered 128-bit accumulator. The previous row sits in a line store of
// MAX_WIDTH words with registered read data; it is read when a word is
// accepted and written when the result is registered, so a read never sees a
// pending write. The store needs no clearing after reset. A new word is
// accepted in the cycle after the result is registered, even while that
// result still waits in the output register.
// ----------------------------------------------------------------------------
module advection_rectangle_stencil
  import ars_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input logic      clk,
  input logic      rst,
  ars_cfg_if.sink  cfg,
  ars_in_if.sink   boundary,
  ars_out_if.source point
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int EXT_W = ((AW > WIDTH_W) ? AW : WIDTH_W) + 1;
  localparam int K_W   = EXT_W + ROW_W + 2;

  state_t state, state_next;

  logic [COEF_W-1:0]  courant;
  logic [COEF_W-1:0]  inv_denominator;
  logic [COEF_W-1:0]  source_scale;
  logic [WIDTH_W-1:0] grid_width;
  logic [ROW_W-1:0]   grid_height;

  logic [AW-1:0]      col;
  logic [ROW_W-1:0]   row;
  logic [VALUE_W-1:0] left_val;
  logic [VALUE_W-1:0] ul_val;

  logic [AW-1:0]      cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [VALUE_W-1:0] bval;
  logic [K_W-1:0]     k_r;
  logic               grid_last;
  logic               edge_pt;

  logic [VALUE_W-1:0] up_val;
  logic [SUM_W-1:0]   diff_r;
  logic [SUM_W-1:0]   sum_r;
  logic [VALUE_W-1:0] prod;
  logic [VALUE_W-1:0] num;
  logic [VALUE_W-1:0] v;
  logic               neg;

  logic [MAG_W-1:0]   mul_a;
  logic [COEF_W-1:0]  mul_b;
  logic [STEP_W-1:0]  step;
  logic               pp_live;
  logic [PROD_W-1:0]  pp;
  logic [1:0]         pp_sh;
  logic [ACC_W-1:0]   acc;

  logic               point_valid;
  logic [VALUE_W-1:0] out_value;
  logic [ROW_W-1:0]   out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic               out_done;

  logic               in_ready;
  logic               in_fire;
  logic               cfg_fire;
  logic               out_free;
  logic               ram_we;
  logic               mul_active;
  logic               mul_done;

  logic [EXT_W-1:0]   col_ext;
  logic [EXT_W-1:0]   cur_col_ext;
  logic [EXT_W-1:0]   gw;
  logic [EXT_W-1:0]   w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic               last_col;
  logic               last_row;
  logic [EXT_W:0]     c_term;
  logic [ROW_W:0]     r_term;
  logic [K_W-1:0]     k_next;

  logic [VALUE_W-1:0] ram_rdata;
  logic [SUM_W-1:0]   up_e, ul_e, left_e;
  logic [SUM_W-1:0]   diff_next, sum_next;
  logic [VALUE_W-1:0] src;
  logic [NUM_W-1:0]   total;
  logic [VALUE_W-1:0] num_next;
  logic [VALUE_W-1:0] num_mag;
  logic [LIMB_W-1:0]  a_limb, b_limb;
  logic [PROD_W-1:0]  pp_prod;
  logic [ACC_W-1:0]   pp_shifted;

  function automatic logic [VALUE_W-1:0] round_sat(input logic [ACC_W-1:0] p,
                                                   input logic is_neg);
    logic [ACC_W-1:0]   rl;
    logic [VALUE_W-1:0] ql;
    logic [QH_W-1:0]    qh;
    logic [VALUE_W-1:0] res;
    rl = p + ROUND_ADD;
    ql = rl[FRAC_W +: VALUE_W];
    qh = rl[ACC_W-1 -: QH_W];
    if (is_neg) begin
      res = (qh != '0 || ql > SAT_MIN) ? SAT_MIN : (~ql + VALUE_W'(1));
    end else begin
      res = (qh != '0 || ql > SAT_MAX) ? SAT_MAX : ql;
    end
    return res;
  endfunction

  ars_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col),
    .wdata (v),
    .raddr (col),
    .rdata (ram_rdata)
  );

  assign in_fire  = boundary.valid && in_ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_free = !point_valid || point.ready;
  assign mul_done = (step == MUL_LAST);

  assign cfg.ready      = 1'b1;
  assign boundary.ready = in_ready;

  assign point.valid        = point_valid;
  assign point.point_value  = out_value;
  assign point.time_row     = out_row;
  assign point.space_column = out_col;
  assign point.grid_done    = out_done;

  // grid geometry and position of the next point
  always_comb begin
    col_ext     = EXT_W'(col);
    cur_col_ext = EXT_W'(cur_col);
    gw          = EXT_W'(grid_width);
    priority if (gw < EXT_W'(2)) begin
      w_eff = EXT_W'(2);
    end else if (gw > EXT_W'(MAX_WIDTH)) begin
      w_eff = EXT_W'(MAX_WIDTH);
    end else begin
      w_eff = gw;
    end
    h_eff    = (grid_height == '0) ? ROW_W'(1) : grid_height;
    last_col = col_ext >= (w_eff - EXT_W'(1));
    last_row = row >= (h_eff - ROW_W'(1));
    c_term   = {col_ext, 1'b1};
    r_term   = {row, 1'b0} - (ROW_W + 1)'(1);
    k_next   = K_W'(c_term) * K_W'(r_term);
  end

  // stencil arithmetic
  always_comb begin
    up_e      = {{(SUM_W - VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};
    ul_e      = {{(SUM_W - VALUE_W){ul_val[VALUE_W-1]}}, ul_val};
    left_e    = {{(SUM_W - VALUE_W){left_val[VALUE_W-1]}}, left_val};
    diff_next = up_e - ul_e - left_e;
    sum_next  = up_e + ul_e - left_e;

    src   = (|acc[ACC_W-1:VALUE_W-1]) ? SAT_MAX : acc[VALUE_W-1:0];
    total = {{(NUM_W - SUM_W){sum_r[SUM_W-1]}}, sum_r}
          - {{(NUM_W - VALUE_W){prod[VALUE_W-1]}}, prod}
          + NUM_W'(src);
    if (&total[NUM_W-1:VALUE_W-1] || !(|total[NUM_W-1:VALUE_W-1])) begin
      num_next = total[VALUE_W-1:0];
    end else begin
      num_next = total[NUM_W-1] ? SAT_MIN : SAT_MAX;
    end
    num_mag = num[VALUE_W-1] ? (~num + VALUE_W'(1)) : num;
  end

  // shared limb multiplier
  always_comb begin
    unique case (step[2:1])
      2'd0:    a_limb = mul_a[LIMB_W-1:0];
      2'd1:    a_limb = mul_a[2*LIMB_W-1:LIMB_W];
      default: a_limb = {{(3*LIMB_W - MAG_W){1'b0}}, mul_a[MAG_W-1:2*LIMB_W]};
    endcase
    b_limb = step[0] ? {{(2*LIMB_W - COEF_W){1'b0}}, mul_b[COEF_W-1:LIMB_W]}
                     : mul_b[LIMB_W-1:0];
    pp_prod    = PROD_W'(a_limb) * PROD_W'(b_limb);
    pp_shifted = {{(ACC_W - PROD_W){1'b0}}, pp} << (LIMB_W * pp_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    mul_active = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (boundary.valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = edge_pt ? ST_DONE : ST_LOAD_C;
      ST_LOAD_C: state_next = ST_MUL_C;
      ST_MUL_C: begin
        mul_active = 1'b1;
        if (mul_done) begin
          state_next = ST_RND_C;
        end
      end
      ST_RND_C:  state_next = ST_MUL_S;
      ST_MUL_S: begin
        mul_active = 1'b1;
        if (mul_done) begin
          state_next = ST_NUM;
        end
      end
      ST_NUM:    state_next = ST_LOAD_R;
      ST_LOAD_R: state_next = ST_MUL_R;
      ST_MUL_R: begin
        mul_active = 1'b1;
        if (mul_done) begin
          state_next = ST_RND_R;
        end
      end
      ST_RND_R:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      courant         <= COURANT_RESET;
      inv_denominator <= INV_DENOM_RESET;
      source_scale    <= SOURCE_SCALE_RESET;
      grid_width      <= GRID_WIDTH_RESET;
      grid_height     <= GRID_HEIGHT_RESET;
      col             <= '0;
      row             <= '0;
      left_val        <= '0;
      ul_val          <= '0;
      step            <= '0;
      pp_live         <= 1'b0;
      point_valid     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_t'(cfg.index))
          CFG_COURANT:      courant         <= cfg.data[COEF_W-1:0];
          CFG_INV_DENOM:    inv_denominator <= cfg.data[COEF_W-1:0];
          CFG_SOURCE_SCALE: source_scale    <= cfg.data[COEF_W-1:0];
          CFG_GRID_WIDTH:   grid_width      <= cfg.data[WIDTH_W-1:0];
          CFG_GRID_HEIGHT:  grid_height     <= cfg.data[ROW_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (!last_col) begin
          col <= col + AW'(1);
        end else begin
          col <= '0;
          row <= last_row ? '0 : (row + ROW_W'(1));
        end
      end

      if (mul_active) begin
        pp_live <= !mul_done;
        if (!mul_done) begin
          step <= step + STEP_W'(1);
        end
      end else begin
        step    <= '0;
        pp_live <= 1'b0;
      end

      if (state == ST_DONE && out_free) begin
        left_val    <= v;
        ul_val      <= up_val;
        point_valid <= 1'b1;
      end else if (point.ready) begin
        point_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_col   <= col;
      cur_row   <= row;
      bval      <= boundary.boundary_value;
      k_r       <= k_next;
      grid_last <= last_col && last_row;
      edge_pt   <= (row == '0) || (col == '0);
    end

    if (mul_active) begin
      pp    <= pp_prod;
      pp_sh <= 2'(step[2:1]) + 2'(step[0]);
      if (pp_live) begin
        acc <= acc + pp_shifted;
      end
    end

    unique case (state)
      ST_READ: begin
        up_val <= ram_rdata;
        diff_r <= diff_next;
        sum_r  <= sum_next;
        if (edge_pt) begin
          v <= bval;
        end
      end
      ST_LOAD_C: begin
        neg   <= diff_r[SUM_W-1];
        mul_a <= diff_r[SUM_W-1] ? (~diff_r + SUM_W'(1)) : diff_r;
        mul_b <= courant;
        acc   <= '0;
      end
      ST_RND_C: begin
        prod  <= round_sat(acc, neg);
        mul_a <= MAG_W'(k_r);
        mul_b <= source_scale;
        acc   <= '0;
      end
      ST_NUM: begin
        num <= num_next;
      end
      ST_LOAD_R: begin
        neg   <= num[VALUE_W-1];
        mul_a <= MAG_W'(num_mag);
        mul_b <= inv_denominator;
        acc   <= '0;
      end
      ST_RND_R: begin
        v <= round_sat(acc, neg);
      end
      ST_DONE: begin
        if (out_free) begin
          out_value <= v;
          out_row   <= cur_row;
          out_col   <= cur_col_ext[COL_OUT_W-1:0];
          out_done  <= grid_last;
        end
      end
      default: ;
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> $past(state) == ST_DONE)
    else $error("output word raised outside the completion state");

  a_edge_fast: assert property (@(posedge clk) disable iff (rst)
    in_fire && (row == '0 || col == '0) |-> ##2 state == ST_DONE)
    else $error("boundary point did not bypass the arithmetic");

  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_col && last_row |=> col == '0 && row == '0)
    else $error("position did not return to the grid origin");

  a_last_partial: assert property (@(posedge clk) disable iff (rst)
    mul_active && mul_done |-> pp_live)
    else $error("final partial product lost before accumulation");

endmodule

@@ hw/rtl/ars_ram.sv @@
// ----------------------------------------------------------------------------
// ars_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ars_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
